// ===== design/spid_pkg.sv =====
// Shared types, constants and tables for the steering PID block.
`timescale 1ns / 1ps
`default_nettype none
package spid_pkg;

  localparam int CordicStepsDefault = 14;
  localparam int AtanEntries = 24;
  localparam int YDistance = 100;
  localparam int CordicScale = 16;
  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth = 24;
  localparam int CordicWidth = 32;
  localparam int AngleWidth = 28;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_KP      = 3'd0,
    REG_KI      = 3'd1,
    REG_KD      = 3'd2,
    REG_DT      = 3'd3,
    REG_INV_DT  = 3'd4,
    REG_ACTUAL  = 3'd5,
    REG_OUT_LO  = 3'd6,
    REG_OUT_HI  = 3'd7
  } cfg_index_t;

  // Job handed from the front end to the back end.
  typedef struct packed {
    logic signed [11:0] diff;
  } job_t;

  // atan(2^-i) in Q24 radians.
  function automatic logic [AngleWidth-1:0] atan_q24(input logic [4:0] i);
    logic [AngleWidth-1:0] r;
    begin
      unique case (i)
        5'd0:  r = 28'd13176795;
        5'd1:  r = 28'd7778716;
        5'd2:  r = 28'd4110060;
        5'd3:  r = 28'd2086331;
        5'd4:  r = 28'd1047214;
        5'd5:  r = 28'd524117;
        5'd6:  r = 28'd262123;
        5'd7:  r = 28'd131069;
        5'd8:  r = 28'd65536;
        5'd9:  r = 28'd32768;
        5'd10: r = 28'd16384;
        5'd11: r = 28'd8192;
        5'd12: r = 28'd4096;
        5'd13: r = 28'd2048;
        5'd14: r = 28'd1024;
        5'd15: r = 28'd512;
        5'd16: r = 28'd256;
        5'd17: r = 28'd128;
        5'd18: r = 28'd64;
        5'd19: r = 28'd32;
        5'd20: r = 28'd16;
        5'd21: r = 28'd8;
        5'd22: r = 28'd4;
        5'd23: r = 28'd2;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

// ===== design/spid_front.sv =====
// Front end: takes target columns, drops negative ones, queues the column difference.
`timescale 1ns / 1ps
`default_nettype none
module spid_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire logic signed [11:0]  target_column,
  input  wire logic [10:0]         actual_column,
  output logic                     job_valid,
  output spid_pkg::job_t           job,
  input  wire logic                job_take
);
  import spid_pkg::*;

  // Two-entry queue of pending jobs.
  job_t       q [2];
  logic       rd_ptr, wr_ptr;
  logic [1:0] count;
  logic       wr_en, rd_en;

  assign full      = (count == 2'd2);
  assign job_valid = (count != 2'd0);
  assign job       = q[rd_ptr];
  assign wr_en     = push && !full && !target_column[11];
  assign rd_en     = job_take && job_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q[wr_ptr].diff <= $signed({1'b0, actual_column}) - target_column;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule
`default_nettype wire

// ===== design/spid_back.sv =====
// Back end: CORDIC atan2 sequencer, PID arithmetic, clamp and result register.
`timescale 1ns / 1ps
`default_nettype none
module spid_back #(
  parameter int CORDIC_STEPS = spid_pkg::CordicStepsDefault
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                job_valid,
  input  wire spid_pkg::job_t      job,
  output logic                     job_take,
  input  wire logic signed [15:0]  kp_gain,
  input  wire logic signed [15:0]  ki_gain,
  input  wire logic signed [15:0]  kd_gain,
  input  wire logic [15:0]         time_step,
  input  wire logic [15:0]         inverse_step,
  input  wire logic signed [23:0]  output_low_limit,
  input  wire logic signed [23:0]  output_high_limit,
  output logic                     empty,
  input  wire logic                pop,
  output logic signed [23:0]       steering_value,
  output logic signed [14:0]       angle_error
);
  import spid_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CORD  = 9'b000000010,
    S_ANGLE = 9'b000000100,
    S_MUL1  = 9'b000001000,
    S_INTEG = 9'b000010000,
    S_MUL2  = 9'b000100000,
    S_MUL3  = 9'b001000000,
    S_SUM   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state;
  logic [4:0] step;
  logic signed [CordicWidth-1:0] cx, cy;
  logic signed [AngleWidth-1:0]  cz;
  logic signed [15:0] err, last_error;
  logic signed [31:0] error_integral;
  logic signed [33:0] prod_a;   // err*dt, then kd*delta
  logic signed [47:0] prod_b;   // ki*integral
  logic signed [31:0] prod_p;   // kp*err
  logic signed [53:0] prod_d;   // kd*delta*inv
  logic signed [55:0] acc;
  logic               out_full;

  logic signed [CordicWidth-1:0] xs, ys;
  logic signed [AngleWidth-1:0]  zr;
  logic signed [17:0] zrnd;
  logic signed [33:0] integ_sum;
  logic signed [55:0] sum_r;
  logic signed [42:0] sum_q;

  assign xs = cx >>> step;
  assign ys = cy >>> step;
  assign zr = cz + (AngleWidth'(1) <<< 10);
  assign zrnd = 18'(zr >>> 11);
  assign integ_sum = 34'(error_integral) + ((prod_a + 34'sd128) >>> 8);
  assign sum_r = acc + (56'sd1 <<< 12);
  assign sum_q = 43'(sum_r >>> 13);

  assign job_take = (state == S_IDLE) && job_valid && !out_full;
  assign empty    = !out_full;

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        cx   <= CordicWidth'(YDistance) <<< CordicScale;
        cy   <= CordicWidth'(job.diff) <<< CordicScale;
        cz   <= '0;
      end
      S_CORD: begin
        if (!cy[CordicWidth-1]) begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + $signed(atan_q24(step));
        end else begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - $signed(atan_q24(step));
        end
      end
      S_ANGLE: begin
        if (zrnd > 18'sd16383) err <= 16'sd16383;
        else if (zrnd < -18'sd16384) err <= -16'sd16384;
        else err <= 16'(zrnd);
      end
      S_MUL1: begin
        prod_a <= 34'(err) * 34'($signed({1'b0, time_step}));
        prod_p <= kp_gain * err;
      end
      S_INTEG: begin
        if (integ_sum > 34'sd2147483647) error_integral <= 32'sh7fffffff;
        else if (integ_sum < -34'sd2147483648) error_integral <= 32'sh80000000;
        else error_integral <= 32'(integ_sum);
        prod_a <= 34'(kd_gain) * 34'(17'(err) - 17'(last_error));
      end
      S_MUL2: begin
        prod_b <= ki_gain * error_integral;
        prod_d <= 54'(prod_a) * 54'($signed({1'b0, inverse_step}));
        last_error <= err;
      end
      S_MUL3: begin
        acc <= 56'(prod_p) + 56'(prod_b) + 56'(prod_d >>> 16);
      end
      S_SUM: begin
        if (sum_q > 43'(output_high_limit)) steering_value <= output_high_limit;
        else if (sum_q < 43'(output_low_limit)) steering_value <= output_low_limit;
        else steering_value <= 24'(sum_q);
        angle_error <= 15'(err);
      end
      default: ;
    endcase
    if (rst) begin
      error_integral <= '0;
      last_error     <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step     <= '0;
      out_full <= 1'b0;
    end else begin
      if (pop && out_full) out_full <= 1'b0;
      unique case (state)
        S_IDLE: begin
          step <= '0;
          if (job_take) state <= (CORDIC_STEPS == 0) ? S_ANGLE : S_CORD;
        end
        S_CORD: begin
          step <= step + 5'd1;
          if (step == 5'(CORDIC_STEPS - 1)) state <= S_ANGLE;
        end
        S_ANGLE: state <= S_MUL1;
        S_MUL1:  state <= S_INTEG;
        S_INTEG: state <= S_MUL2;
        S_MUL2:  state <= S_MUL3;
        S_MUL3:  state <= S_SUM;
        S_SUM:   state <= S_OUT;
        S_OUT: begin
          out_full <= 1'b1;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/steering_pid_from_pixel_offset_unit.sv =====
// Top level of the steering PID: config registers, front end and back end.
`timescale 1ns / 1ps
`default_nettype none
// Steering PID controller fed by target pixel columns. Push a target column;
// a negative column is dropped with no transaction on the result side. Each
// kept column is queued (two deep) in the front end, then the back end takes
// it in its idle cycle, runs a vectoring CORDIC atan2(actual - target, 100)
// over CORDIC_STEPS iterations, one shift-add iteration per cycle, followed by
// angle rounding, multiply, clamp and result staging.
// The single result register holds one finished transaction; the back end
// waits for it to be popped before it starts the next item, while the front
// queue still takes pushes. Configuration writes are always ready and must be
// done while the block is idle.
module steering_pid_from_pixel_offset_unit #(
  parameter int CORDIC_STEPS = spid_pkg::CordicStepsDefault
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire logic signed [11:0]  target_column,
  output logic                     empty,
  input  wire logic                pop,
  output logic signed [23:0]       steering_value,
  output logic signed [14:0]       angle_error,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [spid_pkg::CfgIndexWidth-1:0] cfg_index,
  input  wire logic [spid_pkg::CfgDataWidth-1:0]  cfg_data
);
  import spid_pkg::*;

  logic signed [15:0] kp_gain, ki_gain, kd_gain;
  logic [15:0]        time_step, inverse_step;
  logic [10:0]        actual_column;
  logic signed [23:0] output_low_limit, output_high_limit;

  job_t job;
  logic job_valid, job_take;

  assign cfg_ready = 1'b1;

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain           <= 16'sd154;
      ki_gain           <= 16'sd77;
      kd_gain           <= 16'sd0;
      time_step         <= 16'd2560;
      inverse_step      <= 16'd6554;
      actual_column     <= 11'd80;
      output_low_limit  <= 24'sd0;
      output_high_limit <= 24'sd23040;
    end else if (cfg_valid) begin
      unique case (cfg_index_t'(cfg_index))
        REG_KP:     kp_gain           <= cfg_data[15:0];
        REG_KI:     ki_gain           <= cfg_data[15:0];
        REG_KD:     kd_gain           <= cfg_data[15:0];
        REG_DT:     time_step         <= cfg_data[15:0];
        REG_INV_DT: inverse_step      <= cfg_data[15:0];
        REG_ACTUAL: actual_column     <= cfg_data[10:0];
        REG_OUT_LO: output_low_limit  <= cfg_data;
        REG_OUT_HI: output_high_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  spid_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .target_column (target_column),
    .actual_column (actual_column),
    .job_valid     (job_valid),
    .job           (job),
    .job_take      (job_take)
  );

  spid_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk               (clk),
    .rst               (rst),
    .job_valid         (job_valid),
    .job               (job),
    .job_take          (job_take),
    .kp_gain           (kp_gain),
    .ki_gain           (ki_gain),
    .kd_gain           (kd_gain),
    .time_step         (time_step),
    .inverse_step      (inverse_step),
    .output_low_limit  (output_low_limit),
    .output_high_limit (output_high_limit),
    .empty             (empty),
    .pop               (pop),
    .steering_value    (steering_value),
    .angle_error       (angle_error)
  );

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the steering PID unit: queue-style driver, result monitor.
`timescale 1ns / 1ps
module tb_top;
  import spid_pkg::*;

  // Q24 arctangent steps, one per CORDIC micro-rotation.
  localparam longint AtanStep [24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };
  localparam int SteerSteps = CordicStepsDefault;
  localparam int SettleCycles = 40;    // longer than the back-end time for one item
  localparam int StallLimit = 2000;    // cycles with no transaction at all

  typedef struct {
    logic signed [23:0] steer;
    logic signed [14:0] angle;
  } steer_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic signed [11:0] target_column = '0;
  logic pop = 1'b0;
  logic cfg_valid = 1'b0;
  cfg_index_t cfg_index = REG_KP;
  logic [CfgDataWidth-1:0] cfg_data = '0;
  logic full, empty, cfg_ready;
  logic signed [23:0] steering_value;
  logic signed [14:0] angle_error;

  steering_pid_from_pixel_offset_unit dut (
    .clk, .rst, .push, .full, .target_column, .empty, .pop,
    .steering_value, .angle_error, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the register file and controller state.
  logic signed [15:0] kp, ki, kd;
  logic [15:0] dt, inv_dt;
  logic [10:0] actual_col;
  logic signed [23:0] out_lo, out_hi;
  longint integral, prev_err;

  logic signed [11:0] pending_targets[$];
  steer_result_t expected_steer[$];
  int cfg_writes = 0, targets_taken = 0, results_seen = 0, dropped = 0;
  int errors = 0, idle_cycles = 0, cycle = 0;
  bit timed_out = 0;
  bit stim_done = 0;

  function automatic longint rshift_round(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // Vectoring CORDIC for atan2(diff, 100), rounded to Q2.13.
  function automatic longint steer_angle(longint diff);
    longint x, y, z, xs, ys;
    x = longint'(YDistance) <<< CordicScale;
    y = diff <<< CordicScale;
    z = 0;
    for (int i = 0; i < SteerSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += AtanStep[i];
      end else begin
        x -= ys; y += xs; z -= AtanStep[i];
      end
    end
    z = rshift_round(z, 11);
    return z > 16383 ? 16383 : (z < -16384 ? -16384 : z);
  endfunction

  // Advance the controller by one kept target; returns the outgoing transaction.
  function automatic steer_result_t pid_update(logic signed [11:0] tgt);
    steer_result_t r;
    longint e, p, it, d, sum;
    e = steer_angle(longint'(actual_col) - longint'(tgt));
    integral += rshift_round(e * longint'(dt), 8);
    if (integral > 64'sd2147483647) integral = 64'sd2147483647;
    if (integral < -64'sd2147483648) integral = -64'sd2147483648;
    p = longint'(kp) * e;
    it = longint'(ki) * integral;
    d = (longint'(kd) * (e - prev_err) * longint'(inv_dt)) >>> 16;
    prev_err = e;
    sum = rshift_round(p + it + d, 13);
    // crossed limits: a sum above the high limit gets it, any other sum the low limit
    if (sum > longint'(out_hi)) sum = out_hi;
    else if (sum < longint'(out_lo)) sum = out_lo;
    r.steer = sum[23:0];
    r.angle = e[14:0];
    return r;
  endfunction

  // Input and config acceptance, sampled at the rising edge.
  always @(posedge clk) begin
    if (!rst && push && !full) begin
      if (!target_column[11]) begin
        expected_steer.push_back(pid_update(target_column));
        targets_taken++;
      end else begin
        dropped++;
      end
      void'(pending_targets.pop_front());
    end
    if (!rst && cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KP:     kp = cfg_data[15:0];
        REG_KI:     ki = cfg_data[15:0];
        REG_KD:     kd = cfg_data[15:0];
        REG_DT:     dt = cfg_data[15:0];
        REG_INV_DT: inv_dt = cfg_data[15:0];
        REG_ACTUAL: actual_col = cfg_data[10:0];
        REG_OUT_LO: out_lo = cfg_data;
        REG_OUT_HI: out_hi = cfg_data;
        default: ;
      endcase
      cfg_writes++;
      cfg_valid <= 1'b0;
    end
  end

  // Result monitor and watchdog.
  always @(posedge clk) begin
    steer_result_t exp_r;
    cycle++;
    if (!rst && pop && !empty) begin
      results_seen++;
      if (expected_steer.size() == 0) begin
        $display("%0t: unexpected transaction steer=%0d angle=%0d",
                 $time, steering_value, angle_error);
        errors++;
      end else begin
        exp_r = expected_steer.pop_front();
        if (steering_value !== exp_r.steer) begin
          $display("%0t: steering_value expected %0d actual %0d",
                   $time, exp_r.steer, steering_value);
          errors++;
        end
        if (angle_error !== exp_r.angle) begin
          $display("%0t: angle_error expected %0d actual %0d",
                   $time, exp_r.angle, angle_error);
          errors++;
        end
      end
    end
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || rst)
      idle_cycles = 0;
    else if (++idle_cycles >= StallLimit)
      timed_out = 1;
  end

  // Sender bursts/gaps and receiver stall patterns, driven on the falling edge.
  int burst_left = 0, gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
      pop <= 1'b0;
    end else begin
      if (burst_left == 0 && gap_left > 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (pending_targets.size() != 0) begin
        if (burst_left == 0) burst_left = $urandom_range(1, 12);
        burst_left--;
        if (burst_left == 0)
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        push <= 1'b1;
        target_column <= pending_targets[0];
      end else begin
        push <= 1'b0;
      end
      case ((cycle >> 8) % 4)
        0: pop <= 1'b1;
        1: pop <= $urandom_range(0, 1);
        2: pop <= (cycle % 32) >= 25;
        default: pop <= $urandom_range(0, 7) == 0;
      endcase
    end
  end

  task automatic write_reg(cfg_index_t idx, logic [CfgDataWidth-1:0] val);
    int n;
    n = cfg_writes;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    wait (cfg_writes != n);
  endtask

  task automatic write_all(int k_p, int k_i, int k_d, int step, int inv_step,
                           int col, int lo, int hi);
    write_reg(REG_KP, CfgDataWidth'(k_p));
    write_reg(REG_KI, CfgDataWidth'(k_i));
    write_reg(REG_KD, CfgDataWidth'(k_d));
    write_reg(REG_DT, CfgDataWidth'(step));
    write_reg(REG_INV_DT, CfgDataWidth'(inv_step));
    write_reg(REG_ACTUAL, CfgDataWidth'(col));
    write_reg(REG_OUT_LO, CfgDataWidth'(lo));
    write_reg(REG_OUT_HI, CfgDataWidth'(hi));
  endtask

  // Drain everything, then let the back end settle before the next config.
  task automatic drain();
    wait (pending_targets.size() == 0 && expected_steer.size() == 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Random targets: mostly within lo_col..hi_col, some full range, some negative.
  task automatic queue_random(int kept, int lo_col, int hi_col);
    int n;
    logic signed [11:0] t;
    n = 0;
    while (n < kept) begin
      case ($urandom_range(0, 9))
        0, 1: t = 12'($urandom());
        2:    t = 12'(-int'($urandom_range(1, 2048)));
        default: t = 12'($urandom_range(lo_col, hi_col));
      endcase
      pending_targets.push_back(t);
      if (!t[11]) n++;
    end
  endtask

  initial begin
    kp = 154; ki = 77; kd = 0; dt = 2560; inv_dt = 6554;
    actual_col = 80; out_lo = 0; out_hi = 23040;
    integral = 0; prev_err = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed, reset settings: zero error, both edges, drops, small offsets.
    pending_targets = '{12'sd80, 12'sd0, 12'sd2047, -12'sd1, -12'sd2048, 12'sd79,
                        12'sd81, 12'sd180, 12'sd1, 12'sd1365, 12'sd682, 12'sd0,
                        12'sd0, 12'sd0};
    drain();

    // Gain and limit extremes, derivative on, wide clamp.
    write_all(32767, -32768, 32767, 65535, 65535, 2047, -8388608, 8388607);
    pending_targets = '{12'sd2047, 12'sd0, 12'sd1024, 12'sd0, 12'sd2047, -12'sd5};
    drain();

    // Zero steps, crossed limits, most negative kp.
    write_all(-32768, 32767, -32768, 0, 0, 0, 1000, -1000);
    pending_targets = '{12'sd0, 12'sd2047, 12'sd100, 12'sd1};
    drain();

    // Wind-up: large same-sign error with the longest step drives the integral
    // toward its upper saturation; gains and limits vary per phase.
    for (int ph = 0; ph < 4; ph++) begin
      write_all($urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 65535), 65535, $urandom_range(0, 65535),
                2047, -$urandom_range(0, 8388608), $urandom_range(0, 8388607));
      queue_random(110, 0, 63);
      drain();
    end

    // Opposite error sign pulls the integral back down; tight clamp.
    write_all(154, 77, 300, 2560, 6554, 0, -23040, 23040);
    queue_random(70, 0, 2047);
    drain();

    // Fully random settings, every register.
    write_all($urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(0, 65535), $urandom_range(0, 2047),
              $urandom(), $urandom());
    queue_random(70, 0, 2047);
    drain();
    stim_done = 1;
  end

  // End of run: all stimulus consumed and every expected transaction seen.
  initial begin
    wait (timed_out || stim_done);
    if (!timed_out) repeat (SettleCycles) @(posedge clk);
    $display("Run covered %0d kept targets, %0d dropped, %0d results, %0d register writes",
             targets_taken, dropped, results_seen, cfg_writes);
    $display("including crossed limits, zero steps and integral wind-up");
    if (timed_out || errors != 0 || expected_steer.size() != 0) begin
      if (expected_steer.size() != 0)
        $display("%0t: %0d expected transactions never arrived", $time,
                 expected_steer.size());
      $display("Test completed with failures");
    end else begin
      $display("Test completed successfully");
    end
    $finish;
  end

endmodule
